// ----- hw/rtl/kvi_pkg.sv -----
// Shared types and constants for the keyframe vec3 interpolator.
// No dependencies.
package kvi_pkg;
   localparam int MaxKeys = 64;
   localparam int IdxW = $clog2(MaxKeys);
   localparam int CntW = $clog2(MaxKeys + 1);
   localparam int ValW = 96;
   localparam int QueueDepth = 2;

   localparam logic [1:0] CMD_APPEND = 2'd0;
   localparam logic [1:0] CMD_CLEAR  = 2'd1;
   localparam logic [1:0] CMD_QUERY  = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef enum logic [1:0] {
      OP_IMM,
      OP_SINGLE,
      OP_INTERP
   } op_type;

   typedef struct packed {
      op_type           op;
      logic [1:0]       status;
      logic [31:0]      qtime;
      logic [CntW-1:0]  count;
   } job_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_RD,
      S_SCAN,
      S_LOAD,
      S_LOAD2,
      S_DIV,
      S_MUL,
      S_ADD,
      S_OUT
   } state_type;
endpackage

// ----- hw/rtl/kvi_ram.sv -----
// Generic single write port RAM with a registered read port.
// No dependencies.
module kvi_ram #(
   parameter int Width = 32,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ----- hw/rtl/kvi_front.sv -----
// Front end: accepts commands, writes keys, keeps the key count, issues jobs.
// Depends on kvi_pkg and kvi_ram.
module kvi_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [199:0]         req_tdata,
   output logic                 job_valid,
   input  logic                 job_ready,
   output kvi_pkg::job_type     job,
   input  logic [kvi_pkg::IdxW-1:0] t_raddr,
   output logic [31:0]          t_rdata,
   input  logic [kvi_pkg::IdxW-1:0] v_raddr,
   output logic [kvi_pkg::ValW-1:0] v_rdata,
   input  logic                 back_busy
);
   import kvi_pkg::*;

   logic [CntW-1:0] count_ff, count_in;
   logic [1:0]      cmd;
   logic            acc, wr;

   assign cmd = req_tdata[1:0];
   assign req_tready = job_ready && !back_busy;
   assign acc = req_tvalid && req_tready;
   assign wr = acc && cmd == CMD_APPEND && count_ff < CntW'(MaxKeys);

   always_comb begin
      count_in = count_ff;
      job = '{op: OP_IMM, status: ST_OK, qtime: req_tdata[161:130], count: count_ff};
      case (cmd)
         CMD_APPEND: begin
            if (wr) count_in = count_ff + 1'b1;
            else job.status = ST_FULL;
         end
         CMD_CLEAR: begin
            if (acc) count_in = '0;
         end
         CMD_QUERY: begin
            if (count_ff == '0) job.status = ST_EMPTY;
            else if (count_ff == CntW'(1)) job.op = OP_SINGLE;
            else job.op = OP_INTERP;
         end
         default: ;
      endcase
   end

   assign job_valid = acc;

   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else count_ff <= count_in;
   end

   kvi_ram #(.Width(32), .Depth(MaxKeys)) u_times (
      .clock(clock), .wr_en(wr), .wr_addr(count_ff[IdxW-1:0]),
      .wr_data(req_tdata[33:2]), .rd_addr(t_raddr), .rd_data(t_rdata));

   kvi_ram #(.Width(ValW), .Depth(MaxKeys)) u_values (
      .clock(clock), .wr_en(wr), .wr_addr(count_ff[IdxW-1:0]),
      .wr_data(req_tdata[129:34]), .rd_addr(v_raddr), .rd_data(v_rdata));
endmodule

// ----- hw/rtl/kvi_queue.sv -----
// Short job queue between front and back end.
// Depends on kvi_pkg.
module kvi_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  kvi_pkg::job_type in_job,
   output logic             out_valid,
   input  logic             out_ready,
   output kvi_pkg::job_type out_job
);
   import kvi_pkg::*;

   localparam int PtrW = $clog2(QueueDepth);
   job_type        slot_ff [QueueDepth];
   logic [PtrW-1:0] wp_ff, rp_ff;
   logic [PtrW:0]  fill_ff;
   logic           push, pop;

   assign in_ready = fill_ff < (PtrW+1)'(QueueDepth);
   assign out_valid = fill_ff != '0;
   assign out_job = slot_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) slot_ff[wp_ff] <= in_job;
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         fill_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 1'b1;
         if (pop) rp_ff <= rp_ff + 1'b1;
         fill_ff <= fill_ff + (PtrW+1)'(push) - (PtrW+1)'(pop);
      end
   end
endmodule

// ----- hw/rtl/kvi_back.sv -----
// Back end: segment scan, serial factor divide, three multiplies, output register.
// Depends on kvi_pkg; reads the key RAMs owned by kvi_front.
module kvi_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     job_valid,
   output logic                     job_ready,
   input  kvi_pkg::job_type         job,
   output logic [kvi_pkg::IdxW-1:0] t_raddr,
   input  logic [31:0]              t_rdata,
   output logic [kvi_pkg::IdxW-1:0] v_raddr,
   input  logic [kvi_pkg::ValW-1:0] v_rdata,
   output logic                     busy,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [103:0]             rsp_tdata
);
   import kvi_pkg::*;

   state_type       state_ff, state_in;
   job_type         job_ff, job_in;
   logic [IdxW:0]   i_ff, i_in;
   logic [IdxW-1:0] seg_ff, seg_in;
   logic [31:0]     t0_ff, t0_in, t1_ff, t1_in;
   logic [ValW-1:0] a_ff, a_in, b_ff, b_in;
   logic [16:0]     f_ff, f_in;
   logic [32:0]     rem_ff, rem_in;
   logic [4:0]      bit_ff, bit_in;
   logic [1:0]      k_ff, k_in;
   logic signed [49:0] p_ff [3];
   logic signed [49:0] p_in;
   logic [95:0]     res_ff, res_in;
   logic [1:0]      st_ff, st_in;
   logic            ov_ff, ov_in;
   logic [32:0]     sub;
   logic signed [32:0] diff;
   logic [31:0]     off, len;

   assign busy = state_ff != S_IDLE;
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata = {6'd0, st_ff, res_ff};
   assign off = job_ff.qtime - t0_ff;
   assign len = t1_ff - t0_ff;
   assign sub = {rem_ff[31:0], 1'b0} - {1'b0, len};

   always_comb begin
      logic [31:0] av, bv;
      av = 32'(a_ff >> (32 * k_ff));
      bv = 32'(b_ff >> (32 * k_ff));
      diff = $signed({bv[31], bv}) - $signed({av[31], av});
      p_in = diff * $signed({1'b0, f_ff});
   end

   always_comb begin
      state_in = state_ff; job_in = job_ff; i_in = i_ff; seg_in = seg_ff;
      t0_in = t0_ff; t1_in = t1_ff; a_in = a_ff; b_in = b_ff; f_in = f_ff;
      rem_in = rem_ff; bit_in = bit_ff; k_in = k_ff; res_in = res_ff;
      st_in = st_ff; ov_in = ov_ff && !rsp_tready;
      job_ready = 1'b0;
      t_raddr = i_ff[IdxW-1:0];
      v_raddr = seg_ff;
      case (state_ff)
         S_IDLE: begin
            job_ready = !ov_ff || rsp_tready;
            if (job_valid && job_ready) begin
               job_in = job;
               i_in = (IdxW+1)'(1);
               seg_in = IdxW'(job.count - CntW'(2));
               t_raddr = '0;
               v_raddr = '0;
               case (job.op)
                  OP_INTERP: state_in = S_RD;
                  OP_SINGLE: state_in = S_LOAD;
                  default: begin
                     res_in = '0; st_in = job.status; ov_in = 1'b1;
                  end
               endcase
            end
         end
         S_RD: state_in = S_SCAN;
         S_SCAN: begin
            if (job_ff.qtime < t_rdata) begin
               seg_in = IdxW'(i_ff - 1'b1);
               state_in = S_LOAD;
            end else if (CntW'(i_ff) + 1'b1 >= job_ff.count) begin
               state_in = S_LOAD;
            end else begin
               i_in = i_ff + 1'b1;
               t_raddr = IdxW'(i_ff + 1'b1);
               state_in = S_RD;
            end
            if (state_in == S_LOAD) t_raddr = seg_in;
            v_raddr = seg_in;
         end
         S_LOAD: begin
            a_in = v_rdata; t0_in = t_rdata;
            if (job_ff.op == OP_SINGLE) begin
               res_in = v_rdata; st_in = ST_OK; ov_in = 1'b1; state_in = S_IDLE;
            end else begin
               t_raddr = seg_ff + 1'b1; v_raddr = seg_ff + 1'b1; state_in = S_LOAD2;
            end
         end
         S_LOAD2: begin
            t_raddr = seg_ff + 1'b1; v_raddr = seg_ff + 1'b1;
            state_in = S_DIV;
            rem_in = '0; bit_in = 5'd16; f_in = '0;
         end
         S_DIV: begin
            if (bit_ff == 5'd16) begin
               b_in = v_rdata; t1_in = t_rdata;
               bit_in = 5'd15;
               if (t_rdata <= t0_ff || job_ff.qtime <= t0_ff) begin
                  f_in = '0; state_in = S_MUL; k_in = '0;
               end else if (off >= t_rdata - t0_ff) begin
                  f_in = 17'h10000; state_in = S_MUL; k_in = '0;
               end else rem_in = {1'b0, off};
            end else begin
               if (!sub[32]) begin
                  rem_in = {1'b0, sub[31:0]}; f_in = {f_ff[15:0], 1'b1};
               end else begin
                  rem_in = {rem_ff[31:0], 1'b0}; f_in = {f_ff[15:0], 1'b0};
               end
               if (bit_ff == '0) begin state_in = S_MUL; k_in = '0; end
               else bit_in = bit_ff - 1'b1;
            end
         end
         S_MUL: begin
            k_in = k_ff + 1'b1;
            if (k_ff == 2'd2) state_in = S_ADD;
         end
         S_ADD: begin
            for (int c = 0; c < 3; c++) begin
               res_in[32*c +: 32] = a_ff[32*c +: 32] + 32'(p_ff[c] >>> 16);
            end
            st_in = ST_OK; ov_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in; i_ff <= i_in; seg_ff <= seg_in; t0_ff <= t0_in;
      t1_ff <= t1_in; a_ff <= a_in; b_ff <= b_in; f_ff <= f_in;
      rem_ff <= rem_in; bit_ff <= bit_in; k_ff <= k_in; res_ff <= res_in;
      st_ff <= st_in;
      if (state_ff == S_MUL) p_ff[k_ff] <= p_in;
      if (reset) begin
         state_ff <= S_IDLE;
         ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ov_ff <= ov_in;
      end
   end
endmodule

// ----- hw/rtl/keyframe_vec3_interpolator_unit.sv -----
// Top level of the keyframe vec3 interpolator.
// Depends on kvi_pkg, kvi_front, kvi_queue and kvi_back.
//
// req_ carries one command word: append a key, clear the table or query.
// rsp_ returns exactly one word per command: x, y, z and a status code.
// The front end writes keys into two RAMs and classifies each command;
// a two-entry job queue feeds the back end, which scans the key times
// through S_RD and S_SCAN, one RAM read per key, runs a restoring divide for
// the factor, then three 33x17 multiplies and an add.
// An interpolating query skips the divide steps when the factor clamps to 0 or 1.
// The scan runs longer for a later segment, up to a full 64-key table.
// Commands are taken only while the back end is idle, as keys and count
// must be settled before the next query.
// Reset (synchronous) empties the table and drops queued and pending words.
// When rsp_tready is low the result is held in the output register and
// the back end waits; the queue then backs up and req_tready falls.
module keyframe_vec3_interpolator_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [199:0] req_tdata,  // cmd, key_time, key_x, key_y, key_z, query_time, pad
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata   // out_x, out_y, out_z, status, pad
);
   import kvi_pkg::*;

   logic            f_valid, f_ready, b_valid, b_ready, busy, pending;
   job_type         f_job, b_job;
   logic [IdxW-1:0] t_raddr, v_raddr;
   logic [31:0]     t_rdata;
   logic [ValW-1:0] v_rdata;

   assign pending = busy || b_valid;

   kvi_front u_front (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .job_valid(f_valid), .job_ready(f_ready), .job(f_job),
      .t_raddr(t_raddr), .t_rdata(t_rdata), .v_raddr(v_raddr), .v_rdata(v_rdata),
      .back_busy(pending));

   kvi_queue u_queue (
      .clock(clock), .reset(reset), .in_valid(f_valid), .in_ready(f_ready),
      .in_job(f_job), .out_valid(b_valid), .out_ready(b_ready), .out_job(b_job));

   kvi_back u_back (
      .clock(clock), .reset(reset), .job_valid(b_valid), .job_ready(b_ready),
      .job(b_job), .t_raddr(t_raddr), .t_rdata(t_rdata), .v_raddr(v_raddr),
      .v_rdata(v_rdata), .busy(busy), .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata));
endmodule
